// ===== hdl/sgi_pkg.sv =====
// Shared types and constants for the segment intersection pipeline.
// No dependencies; imported by every module of the block.
package sgi_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int EPS_W           = 8;
	localparam int OUT_W           = 32;
	localparam int ACT_W           = 2;

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

	localparam logic [ACT_W-1:0] ACT_LINE_LINE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LINE_SEG  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SEG_SEG   = 2'd2;
	localparam logic [ACT_W-1:0] ACT_SPARE     = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             par;
		logic             neg_x;
		logic             neg_y;
	} ctl_t;

endpackage

// ===== hdl/segment_intersection.sv =====
// Segment intersection by Cramer's rule: front arithmetic, bit-serial divider pipeline, back end.
// Throughput: one item per cycle; the whole pipeline holds while a result waits under out_stall.
// The divider pipeline, one quotient bit per stage, sets the depth.
// Reset clears all valid bits and sets epsilon to 1; depends on sgi_pkg.
module segment_intersection #(
	parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sgi_pkg::ACT_W-1:0]        action,
	input  logic signed [COORD_WIDTH-1:0]    first_start_x,
	input  logic signed [COORD_WIDTH-1:0]    first_start_y,
	input  logic signed [COORD_WIDTH-1:0]    first_end_x,
	input  logic signed [COORD_WIDTH-1:0]    first_end_y,
	input  logic signed [COORD_WIDTH-1:0]    second_start_x,
	input  logic signed [COORD_WIDTH-1:0]    second_start_y,
	input  logic signed [COORD_WIDTH-1:0]    second_end_x,
	input  logic signed [COORD_WIDTH-1:0]    second_end_y,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic                             parallel,
	output logic signed [sgi_pkg::OUT_W-1:0] cross_x,
	output logic signed [sgi_pkg::OUT_W-1:0] cross_y,
	output logic                             saturated,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sgi_pkg::EPS_W-1:0]        cfg_data
);
	import sgi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int NQ = 3 * W + 3;
	localparam int DW = 2 * W + 3;
	localparam int SW = 8 * W;

	logic             en;
	logic [EPS_W-1:0] eps_q;

	logic             f_v, d_v;
	ctl_t             f_ctl, d_ctl;
	logic [NQ-1:0]    f_nx, f_ny, d_qx, d_qy;
	logic [DW-1:0]    f_d;
	logic [SW-1:0]    f_bnd, d_bnd;

	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			eps_q <= cfg_data;
		end
	end

	sgi_front #(.W(W)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (in_valid),
		.action (action),
		.sx1    (first_start_x),
		.sy1    (first_start_y),
		.ex1    (first_end_x),
		.ey1    (first_end_y),
		.sx2    (second_start_x),
		.sy2    (second_start_y),
		.ex2    (second_end_x),
		.ey2    (second_end_y),
		.v_o    (f_v),
		.ctl_o  (f_ctl),
		.nx_o   (f_nx),
		.ny_o   (f_ny),
		.d_o    (f_d),
		.bnd_o  (f_bnd)
	);

	sgi_div #(.NQ(NQ), .DW(DW), .SW(SW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (f_v),
		.ctl_i  (f_ctl),
		.nx_i   (f_nx),
		.ny_i   (f_ny),
		.d_i    (f_d),
		.side_i (f_bnd),
		.v_o    (d_v),
		.ctl_o  (d_ctl),
		.qx_o   (d_qx),
		.qy_o   (d_qy),
		.side_o (d_bnd)
	);

	sgi_back #(.W(W), .NQ(NQ)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_i       (d_v),
		.ctl_i     (d_ctl),
		.qx_i      (d_qx),
		.qy_i      (d_qy),
		.bnd_i     (d_bnd),
		.eps       (eps_q),
		.out_valid (out_valid),
		.hit       (hit),
		.parallel  (parallel),
		.cross_x   (cross_x),
		.cross_y   (cross_y),
		.saturated (saturated)
	);

endmodule

// ===== hdl/sgi_front.sv =====
// Front pipeline: line coefficients, determinant, Cramer numerators, magnitudes.
// Five register stages; depends on sgi_pkg.
module sgi_front #(
	parameter int W = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                v_i,
	input  logic [sgi_pkg::ACT_W-1:0]           action,
	input  logic signed [W-1:0]                 sx1,
	input  logic signed [W-1:0]                 sy1,
	input  logic signed [W-1:0]                 ex1,
	input  logic signed [W-1:0]                 ey1,
	input  logic signed [W-1:0]                 sx2,
	input  logic signed [W-1:0]                 sy2,
	input  logic signed [W-1:0]                 ex2,
	input  logic signed [W-1:0]                 ey2,
	output logic                                v_o,
	output sgi_pkg::ctl_t                       ctl_o,
	output logic [3*W+2:0]                      nx_o,
	output logic [3*W+2:0]                      ny_o,
	output logic [2*W+2:0]                      d_o,
	output logic [8*W-1:0]                      bnd_o
);
	import sgi_pkg::*;

	localparam int AW = W + 1;
	localparam int CW = 2 * W + 1;
	localparam int MW = 2 * W + 2;
	localparam int DW = 2 * W + 3;
	localparam int PW = 3 * W + 2;
	localparam int NW = 3 * W + 3;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ACT_W-1:0]    act_s1, act_s2, act_s3, act_s4;
	logic [8*W-1:0]      bnd_s1, bnd_s2, bnd_s3, bnd_s4, bnd_s5;

	logic signed [AW-1:0]  a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [2*W-1:0] p1_s1, q1_s1, p2_s1, q2_s1;

	logic signed [AW-1:0]  a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [CW-1:0]  c1_s2, c2_s2;
	logic signed [MW-1:0]  ab_s2, ba_s2;

	logic signed [DW-1:0]  d_s3;
	logic signed [PW-1:0]  m1_s3, m2_s3, m3_s3, m4_s3;

	logic signed [DW-1:0]  d_s4;
	logic signed [NW-1:0]  nx_s4, ny_s4;

	ctl_t                  ctl_s5;
	logic [NW-1:0]         nx_s5, ny_s5;
	logic [DW-1:0]         d_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= action;
			a1_s1  <= AW'(sy1) - AW'(ey1);
			b1_s1  <= AW'(ex1) - AW'(sx1);
			a2_s1  <= AW'(sy2) - AW'(ey2);
			b2_s1  <= AW'(ex2) - AW'(sx2);
			p1_s1  <= sx1 * ey1;
			q1_s1  <= ex1 * sy1;
			p2_s1  <= sx2 * ey2;
			q2_s1  <= ex2 * sy2;
			bnd_s1 <= {(ey2 < sy2) ? sy2 : ey2, (ey2 < sy2) ? ey2 : sy2,
				(ex2 < sx2) ? sx2 : ex2, (ex2 < sx2) ? ex2 : sx2,
				(ey1 < sy1) ? sy1 : ey1, (ey1 < sy1) ? ey1 : sy1,
				(ex1 < sx1) ? sx1 : ex1, (ex1 < sx1) ? ex1 : sx1};

			act_s2 <= act_s1;
			bnd_s2 <= bnd_s1;
			a1_s2  <= a1_s1;
			b1_s2  <= b1_s1;
			a2_s2  <= a2_s1;
			b2_s2  <= b2_s1;
			c1_s2  <= CW'(p1_s1) - CW'(q1_s1);
			c2_s2  <= CW'(p2_s1) - CW'(q2_s1);
			ab_s2  <= a1_s1 * b2_s1;
			ba_s2  <= b1_s1 * a2_s1;

			act_s3 <= act_s2;
			bnd_s3 <= bnd_s2;
			d_s3   <= DW'(ab_s2) - DW'(ba_s2);
			m1_s3  <= b1_s2 * c2_s2;
			m2_s3  <= c1_s2 * b2_s2;
			m3_s3  <= c1_s2 * a2_s2;
			m4_s3  <= a1_s2 * c2_s2;

			act_s4 <= act_s3;
			bnd_s4 <= bnd_s3;
			d_s4   <= d_s3;
			nx_s4  <= NW'(m1_s3) - NW'(m2_s3);
			ny_s4  <= NW'(m3_s3) - NW'(m4_s3);

			bnd_s5        <= bnd_s4;
			ctl_s5.action <= act_s4;
			ctl_s5.par    <= (d_s4 == '0);
			ctl_s5.neg_x  <= nx_s4[NW-1] ^ d_s4[DW-1];
			ctl_s5.neg_y  <= ny_s4[NW-1] ^ d_s4[DW-1];
			nx_s5         <= nx_s4[NW-1] ? NW'(-nx_s4) : NW'(nx_s4);
			ny_s5         <= ny_s4[NW-1] ? NW'(-ny_s4) : NW'(ny_s4);
			d_s5          <= d_s4[DW-1] ? DW'(-d_s4) : DW'(d_s4);
		end
	end

	assign v_o   = v_s5;
	assign ctl_o = ctl_s5;
	assign nx_o  = nx_s5;
	assign ny_o  = ny_s5;
	assign d_o   = d_s5;
	assign bnd_o = bnd_s5;

endmodule

// ===== hdl/sgi_div.sv =====
// Pipelined restoring divider: two numerators over one divisor, one quotient bit per stage.
// Carries control and side data alongside; depends on sgi_pkg.
module sgi_div #(
	parameter int NQ = 51,
	parameter int DW = 35,
	parameter int SW = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_i,
	input  sgi_pkg::ctl_t       ctl_i,
	input  logic [NQ-1:0]       nx_i,
	input  logic [NQ-1:0]       ny_i,
	input  logic [DW-1:0]       d_i,
	input  logic [SW-1:0]       side_i,
	output logic                v_o,
	output sgi_pkg::ctl_t       ctl_o,
	output logic [NQ-1:0]       qx_o,
	output logic [NQ-1:0]       qy_o,
	output logic [SW-1:0]       side_o
);
	import sgi_pkg::*;

	logic          v_sk    [NQ];
	ctl_t          ctl_sk  [NQ];
	logic [DW-1:0] rx_sk   [NQ];
	logic [DW-1:0] ry_sk   [NQ];
	logic [DW-1:0] d_sk    [NQ];
	logic [NQ-1:0] nx_sk   [NQ];
	logic [NQ-1:0] ny_sk   [NQ];
	logic [NQ-1:0] qx_sk   [NQ];
	logic [NQ-1:0] qy_sk   [NQ];
	logic [SW-1:0] side_sk [NQ];

	for (genvar k = 0; k < NQ; k++) begin : g_stage
		logic          c_v;
		ctl_t          c_ctl;
		logic [DW-1:0] c_rx, c_ry, c_d;
		logic [NQ-1:0] c_nx, c_ny, c_qx, c_qy;
		logic [SW-1:0] c_side;
		logic [DW:0]   tx, ty;
		logic          gx, gy;

		if (k == 0) begin : g_first
			assign c_v    = v_i;
			assign c_ctl  = ctl_i;
			assign c_rx   = '0;
			assign c_ry   = '0;
			assign c_d    = d_i;
			assign c_nx   = nx_i;
			assign c_ny   = ny_i;
			assign c_qx   = '0;
			assign c_qy   = '0;
			assign c_side = side_i;
		end else begin : g_next
			assign c_v    = v_sk[k-1];
			assign c_ctl  = ctl_sk[k-1];
			assign c_rx   = rx_sk[k-1];
			assign c_ry   = ry_sk[k-1];
			assign c_d    = d_sk[k-1];
			assign c_nx   = nx_sk[k-1];
			assign c_ny   = ny_sk[k-1];
			assign c_qx   = qx_sk[k-1];
			assign c_qy   = qy_sk[k-1];
			assign c_side = side_sk[k-1];
		end

		assign tx = {c_rx, c_nx[NQ-1]};
		assign ty = {c_ry, c_ny[NQ-1]};
		assign gx = (tx >= {1'b0, c_d});
		assign gy = (ty >= {1'b0, c_d});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else if (en) begin
				v_sk[k] <= c_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_sk[k]  <= c_ctl;
				d_sk[k]    <= c_d;
				side_sk[k] <= c_side;
				nx_sk[k]   <= c_nx << 1;
				ny_sk[k]   <= c_ny << 1;
				rx_sk[k]   <= gx ? DW'(tx - {1'b0, c_d}) : tx[DW-1:0];
				ry_sk[k]   <= gy ? DW'(ty - {1'b0, c_d}) : ty[DW-1:0];
				qx_sk[k]   <= {c_qx[NQ-2:0], gx};
				qy_sk[k]   <= {c_qy[NQ-2:0], gy};
			end
		end
	end

	assign v_o    = v_sk[NQ-1];
	assign ctl_o  = ctl_sk[NQ-1];
	assign qx_o   = qx_sk[NQ-1];
	assign qy_o   = qy_sk[NQ-1];
	assign side_o = side_sk[NQ-1];

endmodule

// ===== hdl/sgi_back.sv =====
// Back pipeline: quotient sign, clamp to 32 bits, widened bounding box tests.
// Two register stages, the second is the output register; depends on sgi_pkg.
module sgi_back #(
	parameter int W  = 16,
	parameter int NQ = 51
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              v_i,
	input  sgi_pkg::ctl_t                     ctl_i,
	input  logic [NQ-1:0]                     qx_i,
	input  logic [NQ-1:0]                     qy_i,
	input  logic [8*W-1:0]                    bnd_i,
	input  logic [sgi_pkg::EPS_W-1:0]         eps,
	output logic                              out_valid,
	output logic                              hit,
	output logic                              parallel,
	output logic signed [sgi_pkg::OUT_W-1:0]  cross_x,
	output logic signed [sgi_pkg::OUT_W-1:0]  cross_y,
	output logic                              saturated
);
	import sgi_pkg::*;

	localparam int XW = (NQ + 1 > OUT_W + 1) ? NQ + 1 : OUT_W + 1;

	localparam logic signed [XW-1:0] MAXV = {{(XW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [XW-1:0] MINV = {{(XW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

	logic                 v_s1;
	ctl_t                 ctl_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic [8*W-1:0]       bnd_s1;

	logic signed [XW:0]   e_ext;
	logic signed [W-1:0]  bv [8];
	logic                 hi_x, lo_x, hi_y, lo_y;
	logic                 box1, box2, hit_c;

	function automatic logic in_range(input logic signed [XW:0] v,
		input logic signed [W-1:0] lo, input logic signed [W-1:0] hi,
		input logic signed [XW:0] e);
		logic signed [XW:0] lo_w, hi_w;
		lo_w = (XW+1)'(lo);
		hi_w = (XW+1)'(hi);
		return (lo_w <= v + e) && (v <= hi_w + e);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= v_i;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_i;
			bnd_s1 <= bnd_i;
			x_s1   <= ctl_i.neg_x ? -$signed(XW'(qx_i)) : $signed(XW'(qx_i));
			y_s1   <= ctl_i.neg_y ? -$signed(XW'(qy_i)) : $signed(XW'(qy_i));
		end
	end

	for (genvar j = 0; j < 8; j++) begin : g_bnd
		assign bv[j] = $signed(bnd_s1[j*W +: W]);
	end

	assign e_ext = $signed((XW+1)'(eps));
	assign hi_x  = (x_s1 > MAXV);
	assign lo_x  = (x_s1 < MINV);
	assign hi_y  = (y_s1 > MAXV);
	assign lo_y  = (y_s1 < MINV);

	assign box1 = in_range((XW+1)'(x_s1), bv[0], bv[1], e_ext)
		&& in_range((XW+1)'(y_s1), bv[2], bv[3], e_ext);
	assign box2 = in_range((XW+1)'(x_s1), bv[4], bv[5], e_ext)
		&& in_range((XW+1)'(y_s1), bv[6], bv[7], e_ext);

	always_comb begin
		unique case (ctl_s1.action)
			ACT_LINE_LINE: hit_c = 1'b1;
			ACT_LINE_SEG:  hit_c = box2;
			default:       hit_c = box1 && box2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			parallel <= ctl_s1.par;
			if (ctl_s1.par) begin
				hit       <= 1'b0;
				cross_x   <= '0;
				cross_y   <= '0;
				saturated <= 1'b0;
			end else begin
				hit       <= hit_c;
				cross_x   <= hi_x ? MAXV[OUT_W-1:0] : (lo_x ? MINV[OUT_W-1:0] : x_s1[OUT_W-1:0]);
				cross_y   <= hi_y ? MAXV[OUT_W-1:0] : (lo_y ? MINV[OUT_W-1:0] : y_s1[OUT_W-1:0]);
				saturated <= hi_x || lo_x || hi_y || lo_y;
			end
		end
	end

endmodule

// ===== hdl/sgi_check.sv =====
// Port-level checks for segment_intersection, bound to every instance.
// Depends on sgi_pkg and the top level's ports.
module sgi_check (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             hit,
	input logic                             parallel,
	input logic signed [sgi_pkg::OUT_W-1:0] cross_x,
	input logic signed [sgi_pkg::OUT_W-1:0] cross_y,
	input logic                             saturated
);
	import sgi_pkg::*;

	localparam logic [OUT_W-1:0] MAXO = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] MINO = {1'b1, {(OUT_W-1){1'b0}}};

	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parallel |-> !hit && !saturated && cross_x == '0 && cross_y == '0)
		else $error("parallel result carries nonzero fields");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> cross_x == MAXO || cross_x == MINO
			|| cross_y == MAXO || cross_y == MINO)
		else $error("saturated without a clamped coordinate");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cross_x) && $stable(cross_y))
		else $error("stalled result changed");

endmodule

bind segment_intersection sgi_check u_check (.*);
